// ===== hw/rtl/tnsf_pkg.sv =====
// Shared types and constants of the nine-sample touch filter.
package tnsf_pkg;

    localparam int GROUPS            = 3;
    localparam int SAMPLES_PER_GROUP = 3;
    localparam int NUM_SUMS          = 2 * GROUPS;
    localparam int GRP_W             = 2;
    localparam int SUM_SEL_W         = 3;
    localparam int POS_W             = 12;
    localparam int THR_W             = 12;

    localparam logic [THR_W-1:0]     THR_RESET = THR_W'(2);
    localparam logic [GRP_W-1:0]     LAST_GRP  = GRP_W'(GROUPS - 1);
    localparam logic [GRP_W-1:0]     LAST_SMP  = GRP_W'(SAMPLES_PER_GROUP - 1);
    localparam logic [SUM_SEL_W-1:0] LAST_SUM  = SUM_SEL_W'(NUM_SUMS - 1);

    typedef enum logic [2:0] {
        ST_ACCUM  = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_EVAL   = 3'b100
    } state_t;

    typedef struct packed {
        logic                 acc_en;
        logic [GRP_W-1:0]     grp_sel;
        logic                 div_en;
        logic [SUM_SEL_W-1:0] div_sel;
        logic                 eval_en;
    } cmd_t;

endpackage

// ===== hw/rtl/tnsf_ctrl.sv =====
// Controller of the touch filter: sample counting, divide sequencing and output handshake.
module tnsf_ctrl
    import tnsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    state_t               state_reg, state_next;
    logic [GRP_W-1:0]     smp_cnt_reg, smp_cnt_next;
    logic [GRP_W-1:0]     grp_cnt_reg, grp_cnt_next;
    logic [SUM_SEL_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 in_acc;
    logic                 out_free;

    assign in_stall  = (state_reg != ST_ACCUM);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        smp_cnt_next   = smp_cnt_reg;
        grp_cnt_next   = grp_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        cmd.acc_en     = 1'b0;
        cmd.grp_sel    = grp_cnt_reg;
        cmd.div_en     = 1'b0;
        cmd.div_sel    = div_cnt_reg;
        cmd.eval_en    = 1'b0;

        case (state_reg)
            ST_ACCUM:
            begin
                if (in_acc)
                begin
                    cmd.acc_en = 1'b1;
                    if (smp_cnt_reg == LAST_SMP)
                    begin
                        smp_cnt_next = '0;
                        if (grp_cnt_reg == LAST_GRP)
                        begin
                            grp_cnt_next = '0;
                            div_cnt_next = '0;
                            state_next   = ST_DIVIDE;
                        end
                        else
                        begin
                            grp_cnt_next = grp_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        smp_cnt_next = smp_cnt_reg + 1'b1;
                    end
                end
            end
            ST_DIVIDE:
            begin
                // One group sum goes through the shared divide-by-three unit per cycle.
                cmd.div_en = 1'b1;
                if (div_cnt_reg == LAST_SUM)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            ST_EVAL:
            begin
                // Wait here until the output register can take the new word.
                if (out_free)
                begin
                    cmd.eval_en = 1'b1;
                    state_next  = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.eval_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            smp_cnt_reg   <= '0;
            grp_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            smp_cnt_reg   <= smp_cnt_next;
            grp_cnt_reg   <= grp_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/tnsf_dpath.sv =====
// Datapath of the touch filter: group sums, shared divide by three, spread check and output word.
module tnsf_dpath
    import tnsf_pkg::*;
#(
    parameter int ADC_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic                cfg_wr,
    input  logic [THR_W-1:0]    cfg_data,
    input  logic [ADC_BITS-1:0] sample_x,
    input  logic [ADC_BITS-1:0] sample_y,
    output logic                touch_valid,
    output logic [POS_W-1:0]    pos_x,
    output logic [POS_W-1:0]    pos_y
);

    localparam int SUM_W     = ADC_BITS + 2;
    localparam int DIV_SHIFT = SUM_W + 2;
    localparam int PROD_W    = SUM_W + DIV_SHIFT;
    localparam int CW        = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;
    localparam logic [DIV_SHIFT-1:0] RECIP = DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);

    logic [SUM_W-1:0]    x_sum_reg [GROUPS];
    logic [SUM_W-1:0]    y_sum_reg [GROUPS];
    logic [ADC_BITS-1:0] avg_reg   [NUM_SUMS];
    logic [THR_W-1:0]    thr_reg;
    logic                touch_valid_reg;
    logic [POS_W-1:0]    pos_x_reg;
    logic [POS_W-1:0]    pos_y_reg;
    logic [SUM_W-1:0]    div_in;
    logic [PROD_W-1:0]   div_prod;
    logic [ADC_BITS-1:0] div_quot;
    logic [POS_W:0]      x_res;
    logic [POS_W:0]      y_res;
    logic                both_pass;

    // Returns the pass flag above the selected mean of one axis.
    function automatic logic [POS_W:0] axis_eval(
        input logic [ADC_BITS-1:0] a0,
        input logic [ADC_BITS-1:0] a1,
        input logic [ADC_BITS-1:0] a2,
        input logic [THR_W-1:0]    thr
    );
        logic [ADC_BITS-1:0] m0;
        logic [ADC_BITS-1:0] m1;
        logic [ADC_BITS-1:0] m2;
        logic [CW-1:0]       t;
        logic [ADC_BITS:0]   pair;
        logic [CW-1:0]       mean;
        logic                pass;
        m0   = (a0 > a1) ? (a0 - a1) : (a1 - a0);
        m1   = (a1 > a2) ? (a1 - a2) : (a2 - a1);
        m2   = (a2 > a0) ? (a2 - a0) : (a0 - a2);
        t    = CW'(thr);
        pass = !((CW'(m0) > t) && (CW'(m1) > t) && (CW'(m2) > t));
        if (m0 < m1)
        begin
            pair = (m2 < m0) ? ({1'b0, a0} + {1'b0, a2}) : ({1'b0, a0} + {1'b0, a1});
        end
        else
        begin
            pair = (m2 < m1) ? ({1'b0, a0} + {1'b0, a2}) : ({1'b0, a1} + {1'b0, a2});
        end
        mean = CW'(pair[ADC_BITS:1]);
        return {pass, mean[POS_W-1:0]};
    endfunction

    always_comb
    begin
        case (cmd.div_sel)
            3'd0:    div_in = x_sum_reg[0];
            3'd1:    div_in = x_sum_reg[1];
            3'd2:    div_in = x_sum_reg[2];
            3'd3:    div_in = y_sum_reg[0];
            3'd4:    div_in = y_sum_reg[1];
            3'd5:    div_in = y_sum_reg[2];
            default: div_in = '0;
        endcase
    end

    // Division by three as a multiplication by a rounded-up reciprocal; exact for every sum.
    assign div_prod = PROD_W'(div_in) * PROD_W'(RECIP);
    assign div_quot = div_prod[DIV_SHIFT +: ADC_BITS];

    assign x_res     = axis_eval(avg_reg[0], avg_reg[1], avg_reg[2], thr_reg);
    assign y_res     = axis_eval(avg_reg[3], avg_reg[4], avg_reg[5], thr_reg);
    assign both_pass = x_res[POS_W] && y_res[POS_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                x_sum_reg[g] <= '0;
                y_sum_reg[g] <= '0;
            end
            thr_reg <= THR_RESET;
        end
        else
        begin
            if (cfg_wr)
            begin
                thr_reg <= cfg_data;
            end
            if (cmd.eval_en)
            begin
                for (int g = 0; g < GROUPS; g++)
                begin
                    x_sum_reg[g] <= '0;
                    y_sum_reg[g] <= '0;
                end
            end
            else if (cmd.acc_en)
            begin
                x_sum_reg[cmd.grp_sel] <= x_sum_reg[cmd.grp_sel] + SUM_W'(sample_x);
                y_sum_reg[cmd.grp_sel] <= y_sum_reg[cmd.grp_sel] + SUM_W'(sample_y);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_en)
        begin
            avg_reg[cmd.div_sel] <= div_quot;
        end
        if (cmd.eval_en)
        begin
            touch_valid_reg <= both_pass;
            pos_x_reg       <= both_pass ? x_res[POS_W-1:0] : '0;
            pos_y_reg       <= both_pass ? y_res[POS_W-1:0] : '0;
        end
    end

    assign touch_valid = touch_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;

endmodule

// ===== hw/rtl/touch_nine_sample_filter.sv =====
// Top level of the nine-sample touch filter: controller and datapath.
//
//   channel  direction  handshake              word
//   input    in         in_valid / in_stall    sample_x, sample_y
//   output   out        out_valid / out_stall  touch_valid, pos_x, pos_y
//   config   in         cfg_valid / cfg_ready  cfg_data (spread threshold)
//
// Sample pairs are taken one per cycle while in_stall is low; after the ninth pair the input
// stalls while the shared divide-by-three unit handles the six group sums one after another,
// during the spread check, and during any wait for the output register.
// Reset clears the group sums and counters and sets the threshold to two.
// The output word is held in a register, so a stalled output only blocks the next set's end.
module touch_nine_sample_filter
    import tnsf_pkg::*;
#(
    parameter int ADC_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ADC_BITS-1:0] sample_x,
    input  logic [ADC_BITS-1:0] sample_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                touch_valid,
    output logic [POS_W-1:0]    pos_x,
    output logic [POS_W-1:0]    pos_y,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [THR_W-1:0]    cfg_data
);

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    tnsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tnsf_dpath #(
        .ADC_BITS (ADC_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .touch_valid (touch_valid),
        .pos_x       (pos_x),
        .pos_y       (pos_y)
    );

endmodule

// ===== dv/touch_nine_sample_filter_tb.sv =====
// Self-checking testbench for the nine-sample touch filter, with its scoreboard.
module touch_nine_sample_filter_tb;
    import tnsf_pkg::*;

    localparam int ADC_W = 12;
    localparam int SUM_W = 14;
    localparam int SETS_PER_PHASE = 16;
    localparam int PHASES = 6;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } touch_word_t;

    class touch_scoreboard;
        logic [THR_W-1:0] threshold;
        logic [SUM_W-1:0] x_sums [GROUPS];
        logic [SUM_W-1:0] y_sums [GROUPS];
        int unsigned      slot;
        touch_word_t      touch_q [$];
        int unsigned      mismatches;
        int unsigned      pairs_seen;
        int unsigned      sets_seen;
        int unsigned      rejects;

        function new();
            threshold  = THR_RESET;
            slot       = 0;
            mismatches = 0;
            pairs_seen = 0;
            sets_seen  = 0;
            rejects    = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            for (int g = 0; g < GROUPS; g++)
            begin
                x_sums[g] = '0;
                y_sums[g] = '0;
            end
        endfunction

        // Spread check and pair selection for one axis; returns 0 on rejection.
        function bit axis_position(input logic [SUM_W-1:0] s0, s1, s2,
                                   output logic [POS_W-1:0] pos);
            int unsigned a0, a1, a2, m0, m1, m2, t;
            a0 = s0 / SAMPLES_PER_GROUP;
            a1 = s1 / SAMPLES_PER_GROUP;
            a2 = s2 / SAMPLES_PER_GROUP;
            m0 = (a0 > a1) ? a0 - a1 : a1 - a0;
            m1 = (a1 > a2) ? a1 - a2 : a2 - a1;
            m2 = (a2 > a0) ? a2 - a0 : a0 - a2;
            t  = threshold;
            pos = '0;
            if (m0 > t && m1 > t && m2 > t)
                return 1'b0;
            if (m0 < m1)
                pos = (m2 < m0) ? POS_W'((a0 + a2) / 2) : POS_W'((a0 + a1) / 2);
            else
                pos = (m2 < m1) ? POS_W'((a0 + a2) / 2) : POS_W'((a1 + a2) / 2);
            return 1'b1;
        endfunction

        function void note_sample(input logic [ADC_W-1:0] sx, sy);
            touch_word_t w;
            logic [POS_W-1:0] px, py;
            bit ok_x, ok_y;
            int unsigned grp;
            grp = slot / SAMPLES_PER_GROUP;
            x_sums[grp] += sx;
            y_sums[grp] += sy;
            pairs_seen++;
            if (slot + 1 < GROUPS * SAMPLES_PER_GROUP)
            begin
                slot++;
                return;
            end
            ok_x = axis_position(x_sums[0], x_sums[1], x_sums[2], px);
            ok_y = axis_position(y_sums[0], y_sums[1], y_sums[2], py);
            w.ok = ok_x && ok_y;
            w.x  = w.ok ? px : '0;
            w.y  = w.ok ? py : '0;
            touch_q.push_back(w);
            sets_seen++;
            if (!w.ok)
                rejects++;
            clear_sums();
            slot = 0;
        endfunction

        function void check_result(input logic ok, input logic [POS_W-1:0] px, py);
            touch_word_t w;
            if (touch_q.size() == 0)
            begin
                $display("%0t: unexpected result word: valid %0b x %0d y %0d",
                         $time, ok, px, py);
                mismatches++;
                return;
            end
            w = touch_q.pop_front();
            if (ok !== w.ok)
            begin
                $display("%0t: touch_valid expected %0b, got %0b", $time, w.ok, ok);
                mismatches++;
            end
            if (px !== w.x)
            begin
                $display("%0t: pos_x expected %0d, got %0d", $time, w.x, px);
                mismatches++;
            end
            if (py !== w.y)
            begin
                $display("%0t: pos_y expected %0d, got %0d", $time, w.y, py);
                mismatches++;
            end
        endfunction

        function int pending();
            return touch_q.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [ADC_W-1:0] sample_x = '0;
    logic [ADC_W-1:0] sample_y = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             touch_valid;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data = '0;

    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;

    touch_scoreboard sb = new();

    touch_nine_sample_filter #(.ADC_BITS(ADC_W)) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .touch_valid (touch_valid),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    // The result word is checked before the input word of the same edge is noted,
    // so a spurious result can never be matched against a set that ends at that edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(touch_valid, pos_x, pos_y);
            if (in_valid && !in_stall)
                sb.note_sample(sample_x, sample_y);
        end
    end

    function automatic logic [ADC_W-1:0] near(input int centre, input int unsigned span);
        int v;
        v = centre + int'($urandom_range(2 * span)) - int'(span);
        if (v < 0)
            v = 0;
        if (v > (1 << ADC_W) - 1)
            v = (1 << ADC_W) - 1;
        return ADC_W'(v);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_pair(input logic [ADC_W-1:0] sx, sy);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_x <= sx;
        sample_y <= sy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_flat_set(input logic [ADC_W-1:0] x0, x1, x2, y0, y1, y2);
        logic [ADC_W-1:0] xg [3];
        logic [ADC_W-1:0] yg [3];
        xg = '{x0, x1, x2};
        yg = '{y0, y1, y2};
        for (int i = 0; i < 9; i++)
            send_pair(xg[i / 3], yg[i / 3]);
    endtask

    // Most sets cluster their groups so that the spread check and the pair
    // selection are exercised near the threshold; a few are pure noise.
    task automatic send_random_set();
        int unsigned spans [6];
        int unsigned gspan, jitter, pick;
        int bx, by;
        logic [ADC_W-1:0] cx [3];
        logic [ADC_W-1:0] cy [3];
        spans = '{0, 1, 2, 3, 8, 200};
        pick = $urandom_range(9);
        if (pick < 2)
        begin
            for (int i = 0; i < 9; i++)
                send_pair(ADC_W'($urandom), ADC_W'($urandom));
            return;
        end
        gspan  = spans[$urandom_range(5)];
        jitter = $urandom_range(3);
        case ($urandom_range(5))
            0:       bx = 0;
            1:       bx = (1 << ADC_W) - 1;
            default: bx = $urandom_range((1 << ADC_W) - 1);
        endcase
        by = (pick == 2) ? bx : int'($urandom_range((1 << ADC_W) - 1));
        for (int g = 0; g < 3; g++)
        begin
            cx[g] = near(bx, gspan);
            cy[g] = near(by, gspan);
        end
        for (int i = 0; i < 9; i++)
            send_pair(near(cx[i / 3], jitter), near(cy[i / 3], jitter));
    endtask

    // Drops the input word first, so that a held pair is not taken again while waiting.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.threshold = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #2_000_000;
        $display("** touch_nine_sample_filter: FAILED **");
        $finish;
    end

    initial
    begin
        logic [THR_W-1:0] thr;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            in_idle_pct   = (phase < 2) ? 27 : (phase < 4) ? 59 : 0;
            out_stall_pct = (phase < 2) ? 59 : (phase < 4) ? 27 : 0;
            if (phase > 0)
            begin
                wait_for_results();
                repeat (SETTLE_CYCLES) @(negedge clk);
                case (phase)
                    1:       thr = '0;
                    2:       thr = '1;
                    3:       thr = THR_W'($urandom);
                    4:       thr = THR_W'(1);
                    default: thr = THR_W'($urandom_range(3, 60));
                endcase
                write_threshold(thr);
            end
            else
            begin
                // Full-scale sums, one axis rejected with the other passing,
                // and the reverse, all under the reset threshold.
                send_flat_set('1, '1, '1, '0, '0, '0);
                send_flat_set('0, '0, '1, '0, ADC_W'(2048), '1);
                send_flat_set('1, ADC_W'(2000), '0, ADC_W'(100), ADC_W'(101), ADC_W'(103));
            end
            for (int s = 0; s < SETS_PER_PHASE; s++)
            begin
                // Hold the input back once per phase until the output side has caught up.
                if (s == SETS_PER_PHASE / 2)
                    wait_for_results();
                send_random_set();
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Run covered %0d sample pairs in %0d sets under %0d threshold settings,",
                 sb.pairs_seen, sb.sets_seen, PHASES);
        $display("with %0d touches rejected and %0d accepted.",
                 sb.rejects, sb.sets_seen - sb.rejects);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** touch_nine_sample_filter: PASSED **");
        else
            $display("** touch_nine_sample_filter: FAILED **");
        $finish;
    end

endmodule
